// ===== design/spc_pkg.sv =====
// Package for the sphere pair contact block: body record, queue entry and codes.
// Used by spc_front, spc_queue, spc_back and sphere_pair_contact_top.
package spc_pkg;

    // Command codes on the input channel.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Bit positions inside the body flags.
    localparam int FLAG_ALIVE  = 0;
    localparam int FLAG_STATIC = 1;
    localparam int FLAG_MASS   = 2;

    // Iteration counts of the square root and the divisions.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 30;

    // Unit length of the normal in Q30.
    localparam logic signed [31:0] UNIT_ONE = 32'sh4000_0000;

    // Number of entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // One stored body.
    typedef struct packed {
        logic signed [31:0] sector_x;
        logic signed [31:0] sector_y;
        logic signed [31:0] sector_z;
        logic signed [31:0] local_x;
        logic signed [31:0] local_y;
        logic signed [31:0] local_z;
        logic signed [31:0] radius;
        logic [2:0]         flags;
    } body_t;

    // One classified item handed from front to back.
    typedef struct packed {
        logic               found;
        logic               a_lt_b;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic [63:0]        dist_sq;
        logic [30:0]        rsum;
    } job_t;

endpackage

// ===== design/spc_queue.sv =====
// Short queue of classified items between the front and the back part.
// Depends on spc_pkg for the entry type and depth.
module spc_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  spc_pkg::job_t wr_data,
    output logic          q_full,
    input  logic          rd_en,
    output spc_pkg::job_t rd_data,
    output logic          q_empty
);

    localparam int PW = (spc_pkg::QUEUE_DEPTH > 1) ? $clog2(spc_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(spc_pkg::QUEUE_DEPTH + 1);

    spc_pkg::job_t  mem [spc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_wr;
    logic           do_rd;

    assign q_full  = (count_reg == CW'(spc_pkg::QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(spc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(spc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/spc_front.sv =====
// Front part: accepts items, keeps the body table and classifies pairs.
// Depends on spc_pkg; feeds spc_queue.
module spc_front #(
    parameter int BODY_SLOTS  = 64,
    parameter int SECTOR_SPAN = 1048576
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               command,
    input  logic [5:0]         index_a,
    input  logic [5:0]         index_b,
    input  logic signed [31:0] sector_x,
    input  logic signed [31:0] sector_y,
    input  logic signed [31:0] sector_z,
    input  logic signed [31:0] local_x,
    input  logic signed [31:0] local_y,
    input  logic signed [31:0] local_z,
    input  logic signed [31:0] body_radius,
    input  logic [2:0]         body_flags,
    output logic               job_valid,
    output spc_pkg::job_t      job,
    input  logic               job_ready
);

    localparam int AW = $clog2(BODY_SLOTS);
    localparam logic signed [34:0] SPAN35 = 35'(SECTOR_SPAN);
    localparam logic signed [34:0] MAX35  = 35'sd2147483647;
    localparam logic signed [34:0] MIN35  = -35'sd2147483648;

    typedef enum logic [2:0] {F_CLEAR, F_IDLE, F_READ, F_SQUARE, F_PUSH} fstate_t;

    spc_pkg::body_t     mem [BODY_SLOTS];
    spc_pkg::body_t     body_a_reg;
    spc_pkg::body_t     body_b_reg;
    fstate_t            state_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic               in_range_reg;
    logic               a_lt_b_reg;
    logic               found_pre_reg;
    logic               found_sq_reg;
    logic signed [31:0] d_reg [3];
    logic [31:0]        mag_reg [3];
    logic [63:0]        sq_reg [3];
    logic [30:0]        rsum_reg;
    logic [61:0]        rsq_reg;

    logic               accept;
    logic               a_ok;
    logic               b_ok;
    logic [AW-1:0]      addr_a;
    logic [AW-1:0]      addr_b;
    spc_pkg::body_t     wr_body;
    logic signed [31:0] sa [3];
    logic signed [31:0] sb [3];
    logic signed [31:0] la [3];
    logic signed [31:0] lb [3];
    logic signed [31:0] d_next [3];
    logic [31:0]        mag_next [3];
    logic               sect_ok;
    logic               dyn_a;
    logic               dyn_b;
    logic signed [32:0] rsum_wide;
    logic signed [31:0] rsum_sat;
    logic               pair_ok;
    logic [63:0]        sq_sum;

    assign accept = push && !full;
    assign full   = (state_reg != F_IDLE);
    assign a_ok   = ({26'd0, index_a} < 32'(BODY_SLOTS));
    assign b_ok   = ({26'd0, index_b} < 32'(BODY_SLOTS));
    assign addr_a = AW'(index_a);
    assign addr_b = AW'(index_b);

    assign wr_body = '{sector_x: sector_x, sector_y: sector_y, sector_z: sector_z,
                       local_x: local_x, local_y: local_y, local_z: local_z,
                       radius: body_radius, flags: body_flags};

    // Body table: clearing pass after reset, writes, and two registered reads.
    always_ff @(posedge clk)
    begin
        if (state_reg == F_CLEAR)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (accept && command == spc_pkg::CMD_WRITE && a_ok)
        begin
            mem[addr_a] <= wr_body;
        end
        if (accept)
        begin
            body_a_reg <= mem[addr_a];
            body_b_reg <= mem[addr_b];
        end
    end

    // Per-axis offsets from a toward b, saturated to 32 bits.
    always_comb
    begin
        logic signed [32:0] sd;
        logic signed [34:0] off;
        sa[0] = body_a_reg.sector_x; sa[1] = body_a_reg.sector_y; sa[2] = body_a_reg.sector_z;
        sb[0] = body_b_reg.sector_x; sb[1] = body_b_reg.sector_y; sb[2] = body_b_reg.sector_z;
        la[0] = body_a_reg.local_x;  la[1] = body_a_reg.local_y;  la[2] = body_a_reg.local_z;
        lb[0] = body_b_reg.local_x;  lb[1] = body_b_reg.local_y;  lb[2] = body_b_reg.local_z;
        sect_ok = 1'b1;
        for (int ax = 0; ax < 3; ax++)
        begin
            sd = 33'(sb[ax]) - 33'(sa[ax]);
            if (sd != 33'sd1 && sd != 33'sd0 && sd != -33'sd1)
            begin
                sect_ok = 1'b0;
            end
            off = 35'(lb[ax]) - 35'(la[ax]);
            if (sd == 33'sd1)
            begin
                off = off + SPAN35;
            end
            else if (sd == -33'sd1)
            begin
                off = off - SPAN35;
            end
            if (off > MAX35)
            begin
                d_next[ax] = 32'sh7FFF_FFFF;
            end
            else if (off < MIN35)
            begin
                d_next[ax] = 32'sh8000_0000;
            end
            else
            begin
                d_next[ax] = off[31:0];
            end
            mag_next[ax] = d_next[ax][31] ? (~d_next[ax] + 32'd1) : d_next[ax];
        end
    end

    // Flag tests and the saturated radius sum.
    always_comb
    begin
        dyn_a = body_a_reg.flags[spc_pkg::FLAG_ALIVE] && !body_a_reg.flags[spc_pkg::FLAG_STATIC]
                && body_a_reg.flags[spc_pkg::FLAG_MASS];
        dyn_b = body_b_reg.flags[spc_pkg::FLAG_ALIVE] && !body_b_reg.flags[spc_pkg::FLAG_STATIC]
                && body_b_reg.flags[spc_pkg::FLAG_MASS];
        rsum_wide = 33'(body_a_reg.radius) + 33'(body_b_reg.radius);
        if (rsum_wide > 33'sd2147483647)
        begin
            rsum_sat = 32'sh7FFF_FFFF;
        end
        else if (rsum_wide < -33'sd2147483648)
        begin
            rsum_sat = 32'sh8000_0000;
        end
        else
        begin
            rsum_sat = rsum_wide[31:0];
        end
        pair_ok = in_range_reg && body_a_reg.flags[spc_pkg::FLAG_ALIVE]
                  && body_b_reg.flags[spc_pkg::FLAG_ALIVE] && (dyn_a || dyn_b)
                  && sect_ok && (rsum_sat > 32'sd0);
    end

    // The three squares fit in 64 bits without overflow.
    assign sq_sum = sq_reg[0] + sq_reg[1] + sq_reg[2];

    // Job handed to the queue.
    assign job_valid = (state_reg == F_PUSH);
    always_comb
    begin
        job.found   = found_sq_reg && (sq_sum < {2'b00, rsq_reg});
        job.a_lt_b  = a_lt_b_reg;
        job.dx      = d_reg[0];
        job.dy      = d_reg[1];
        job.dz      = d_reg[2];
        job.dist_sq = sq_sum;
        job.rsum    = rsum_reg;
    end

    // Sequencer of the front part.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_CLEAR;
            clr_cnt_reg   <= '0;
            in_range_reg  <= 1'b0;
            a_lt_b_reg    <= 1'b0;
            found_pre_reg <= 1'b0;
            found_sq_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                F_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(BODY_SLOTS - 1))
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                F_IDLE:
                begin
                    if (accept)
                    begin
                        in_range_reg <= a_ok && b_ok;
                        a_lt_b_reg   <= (index_a < index_b);
                        found_sq_reg <= 1'b0;
                        state_reg    <= (command == spc_pkg::CMD_QUERY) ? F_READ : F_PUSH;
                    end
                end
                F_READ:
                begin
                    found_pre_reg <= pair_ok;
                    rsum_reg      <= rsum_sat[30:0];
                    for (int ax = 0; ax < 3; ax++)
                    begin
                        d_reg[ax]   <= d_next[ax];
                        mag_reg[ax] <= mag_next[ax];
                    end
                    state_reg <= F_SQUARE;
                end
                F_SQUARE:
                begin
                    found_sq_reg <= found_pre_reg;
                    for (int ax = 0; ax < 3; ax++)
                    begin
                        sq_reg[ax] <= mag_reg[ax] * mag_reg[ax];
                    end
                    rsq_reg   <= rsum_reg * rsum_reg;
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (job_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/spc_back.sv =====
// Back part: square root, three unit divisions and the result register.
// Depends on spc_pkg; takes jobs from spc_queue.
module spc_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  spc_pkg::job_t      q_data,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output logic               contact_found,
    output logic signed [31:0] normal_x,
    output logic signed [31:0] normal_y,
    output logic signed [31:0] normal_z,
    output logic [30:0]        penetration
);

    typedef enum logic [2:0] {B_IDLE, B_SQRT, B_SETUP, B_DIV, B_DONE} bstate_t;

    bstate_t            state_reg;
    spc_pkg::job_t      job_reg;
    logic [63:0]        val_reg;
    logic [35:0]        rem_reg;
    logic [31:0]        root_reg;
    logic [4:0]         cnt_reg;
    logic [31:0]        drem_reg [3];
    logic [29:0]        q_reg [3];
    logic               unit_reg [3];
    logic               out_valid_reg;
    logic               found_out_reg;
    logic signed [31:0] nx_out_reg;
    logic signed [31:0] ny_out_reg;
    logic signed [31:0] nz_out_reg;
    logic [30:0]        pen_out_reg;

    logic [35:0]        rem_sh;
    logic [31:0]        root_sh;
    logic [35:0]        cand;
    logic [35:0]        rem_next;
    logic [31:0]        root_next;
    logic [31:0]        mag [3];
    logic signed [31:0] dsig [3];
    logic [31:0]        drem_next [3];
    logic [29:0]        q_next [3];
    logic signed [31:0] n_res [3];
    logic [31:0]        pen_wide;
    logic               out_free;

    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;

    assign contact_found = found_out_reg;
    assign normal_x      = nx_out_reg;
    assign normal_y      = ny_out_reg;
    assign normal_z      = nz_out_reg;
    assign penetration   = pen_out_reg;

    // One step of the restoring square root.
    always_comb
    begin
        rem_sh  = {rem_reg[33:0], val_reg[63:62]};
        root_sh = {root_reg[30:0], 1'b0};
        cand    = 36'({root_sh, 1'b1});
        if (rem_sh >= cand)
        begin
            rem_next  = rem_sh - cand;
            root_next = root_sh + 32'd1;
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = root_sh;
        end
    end

    // One step of each restoring division, and the signed results.
    always_comb
    begin
        logic [32:0] dsh;
        logic [30:0] f;
        dsig[0] = job_reg.dx;
        dsig[1] = job_reg.dy;
        dsig[2] = job_reg.dz;
        for (int ax = 0; ax < 3; ax++)
        begin
            mag[ax] = dsig[ax][31] ? (~dsig[ax] + 32'd1) : dsig[ax];
            dsh = {drem_reg[ax], 1'b0};
            if (dsh >= {1'b0, root_reg})
            begin
                drem_next[ax] = 32'(dsh - {1'b0, root_reg});
                q_next[ax]    = {q_reg[ax][28:0], 1'b1};
            end
            else
            begin
                drem_next[ax] = dsh[31:0];
                q_next[ax]    = {q_reg[ax][28:0], 1'b0};
            end
            f = unit_reg[ax] ? 31'(spc_pkg::UNIT_ONE) : {1'b0, q_reg[ax]};
            n_res[ax] = dsig[ax][31] ? -32'(f) : 32'(f);
        end
        pen_wide = {1'b0, job_reg.rsum} - root_reg;
    end

    // Sequencer of the back part and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            // A result taken while a new one is loaded is replaced in B_DONE.
            if (pop && out_valid_reg && state_reg != B_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        job_reg   <= q_data;
                        val_reg   <= q_data.dist_sq;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= q_data.found ? B_SQRT : B_DONE;
                    end
                end
                B_SQRT:
                begin
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    val_reg  <= {val_reg[61:0], 2'b00};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'(spc_pkg::SQRT_STEPS - 1))
                    begin
                        state_reg <= B_SETUP;
                    end
                end
                B_SETUP:
                begin
                    for (int ax = 0; ax < 3; ax++)
                    begin
                        drem_reg[ax] <= mag[ax];
                        q_reg[ax]    <= '0;
                        unit_reg[ax] <= (mag[ax] >= root_reg);
                    end
                    cnt_reg   <= '0;
                    state_reg <= (root_reg == '0) ? B_DONE : B_DIV;
                end
                B_DIV:
                begin
                    for (int ax = 0; ax < 3; ax++)
                    begin
                        drem_reg[ax] <= drem_next[ax];
                        q_reg[ax]    <= q_next[ax];
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'(spc_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= B_DONE;
                    end
                end
                B_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        found_out_reg <= job_reg.found;
                        if (!job_reg.found)
                        begin
                            nx_out_reg  <= '0;
                            ny_out_reg  <= '0;
                            nz_out_reg  <= '0;
                            pen_out_reg <= '0;
                        end
                        else
                        begin
                            pen_out_reg <= pen_wide[30:0];
                            if (root_reg == '0)
                            begin
                                nx_out_reg <= job_reg.a_lt_b ? spc_pkg::UNIT_ONE
                                                             : -spc_pkg::UNIT_ONE;
                                ny_out_reg <= '0;
                                nz_out_reg <= '0;
                            end
                            else
                            begin
                                nx_out_reg <= n_res[0];
                                ny_out_reg <= n_res[1];
                                nz_out_reg <= n_res[2];
                            end
                        end
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/sphere_pair_contact_top.sv =====
// Sphere pair contact: a write passes F_PUSH, the queue, B_IDLE and B_DONE; a query
// that misses adds F_READ and F_SQUARE, an overlapping one also B_SQRT, B_SETUP and
// B_DIV (B_DIV is skipped for coincident centers). Overlapping queries are paced by
// the 32-step square root and the 30-step divisions in the back part; the front takes
// a new item once its last one is pushed. After reset the body table is cleared one
// slot a cycle, every slot, with full held high; the result queue starts empty.
module sphere_pair_contact_top #(
    parameter int BODY_SLOTS  = 64,
    parameter int SECTOR_SPAN = 1048576
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               command,
    input  logic [5:0]         index_a,
    input  logic [5:0]         index_b,
    input  logic signed [31:0] sector_x,
    input  logic signed [31:0] sector_y,
    input  logic signed [31:0] sector_z,
    input  logic signed [31:0] local_x,
    input  logic signed [31:0] local_y,
    input  logic signed [31:0] local_z,
    input  logic signed [31:0] body_radius,
    input  logic [2:0]         body_flags,
    output logic               empty,
    input  logic               pop,
    output logic               contact_found,
    output logic signed [31:0] normal_x,
    output logic signed [31:0] normal_y,
    output logic signed [31:0] normal_z,
    output logic [30:0]        penetration
);

    logic          job_valid;
    spc_pkg::job_t job;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    spc_pkg::job_t q_data;

    // Front part: table and classification.
    spc_front #(
        .BODY_SLOTS  (BODY_SLOTS),
        .SECTOR_SPAN (SECTOR_SPAN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .index_a     (index_a),
        .index_b     (index_b),
        .sector_x    (sector_x),
        .sector_y    (sector_y),
        .sector_z    (sector_z),
        .local_x     (local_x),
        .local_y     (local_y),
        .local_z     (local_z),
        .body_radius (body_radius),
        .body_flags  (body_flags),
        .job_valid   (job_valid),
        .job         (job),
        .job_ready   (!q_full)
    );

    // Queue between the two parts.
    spc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_valid),
        .wr_data (job),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_empty (q_empty)
    );

    // Back part: root, divisions and result register.
    spc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .contact_found (contact_found),
        .normal_x      (normal_x),
        .normal_y      (normal_y),
        .normal_z      (normal_z),
        .penetration   (penetration)
    );

endmodule

// ===== test/spc_checker.sv =====
// Checker for the sphere pair contact block: watches both queue channels,
// predicts every result from its own copy of the body table and compares.
// Depends on spc_pkg for the command codes and flag bit positions.
module spc_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic               command,
    input  logic [5:0]         index_a,
    input  logic [5:0]         index_b,
    input  logic signed [31:0] sector_x,
    input  logic signed [31:0] sector_y,
    input  logic signed [31:0] sector_z,
    input  logic signed [31:0] local_x,
    input  logic signed [31:0] local_y,
    input  logic signed [31:0] local_z,
    input  logic signed [31:0] body_radius,
    input  logic [2:0]         body_flags,
    input  logic               empty,
    input  logic               pop,
    input  logic               contact_found,
    input  logic signed [31:0] normal_x,
    input  logic signed [31:0] normal_y,
    input  logic signed [31:0] normal_z,
    input  logic [30:0]        penetration,
    output int                 fail_count,
    output int                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SPAN = 1048576;

    typedef struct packed {
        logic               found;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic [30:0]        pen;
    } contact_t;

    // Shadow copy of the body table.
    longint    tab_sector [64][3];
    longint    tab_local  [64][3];
    longint    tab_radius [64];
    logic [2:0] tab_flags [64];

    contact_t expected_contacts[$];

    assign pending_count = expected_contacts.size();

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [31:0] root_of(logic [63:0] v);
        logic [65:0] rem;
        logic [31:0] r;
        logic [65:0] trial;
        rem = '0;
        r = '0;
        for (int i = 0; i < 32; i++)
        begin
            r = r << 1;
            rem = (rem << 2) | v[63:62];
            v = v << 2;
            trial = {r, 1'b1};
            if (rem >= trial)
            begin
                rem = rem - trial;
                r = r + 1;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] unit_ratio(logic [31:0] num, logic [31:0] den);
        logic [63:0] rem;
        logic [31:0] q;
        rem = num;
        q = '0;
        if (den == 0 || num >= den) return 32'h4000_0000;
        for (int i = 0; i < 30; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic is_dyn(logic [2:0] f);
        return f[spc_pkg::FLAG_ALIVE] && !f[spc_pkg::FLAG_STATIC] && f[spc_pkg::FLAG_MASS];
    endfunction

    // Work out the result of one query against the shadow table.
    function automatic contact_t predict_contact(int a, int b);
        contact_t c;
        longint d[3];
        longint sd, mag, rsum, f;
        logic [63:0] sq, c2, rsq;
        logic [31:0] root_len;
        c = '0;
        sq = '0;
        if (!tab_flags[a][spc_pkg::FLAG_ALIVE] || !tab_flags[b][spc_pkg::FLAG_ALIVE]) return c;
        if (!is_dyn(tab_flags[a]) && !is_dyn(tab_flags[b])) return c;
        for (int ax = 0; ax < 3; ax++)
        begin
            sd = tab_sector[b][ax] - tab_sector[a][ax];
            if (sd < -1 || sd > 1) return c;
            d[ax] = clamp32(sd * SPAN + tab_local[b][ax] - tab_local[a][ax]);
            mag = d[ax] < 0 ? -d[ax] : d[ax];
            c2 = mag * mag;
            sq = (sq > ~c2) ? '1 : sq + c2;
        end
        rsum = clamp32(tab_radius[a] + tab_radius[b]);
        if (rsum <= 0) return c;
        rsq = rsum * rsum;
        if (sq >= rsq) return c;
        root_len = root_of(sq);
        c.found = 1'b1;
        if (root_len == 0)
            c.nx = (a < b) ? 32'sh4000_0000 : -32'sh4000_0000;
        else
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                mag = d[ax] < 0 ? -d[ax] : d[ax];
                f = unit_ratio(mag[31:0], root_len);
                if (d[ax] < 0) f = -f;
                if (ax == 0) c.nx = f[31:0];
                else if (ax == 1) c.ny = f[31:0];
                else c.nz = f[31:0];
            end
        end
        f = clamp32(rsum - longint'(root_len));
        if (f < 0) f = 0;
        c.pen = f[30:0];
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Input side: update the shadow table or queue a prediction per transfer.
    always @(posedge clk or negedge rst_n)
    begin
        contact_t c;
        if (!rst_n)
        begin
            for (int i = 0; i < 64; i++)
                tab_flags[i] = '0;
        end
        else if (push && !full)
        begin
            c = '0;
            if (command == spc_pkg::CMD_WRITE)
            begin
                tab_sector[index_a] = '{sector_x, sector_y, sector_z};
                tab_local[index_a]  = '{local_x, local_y, local_z};
                tab_radius[index_a] = body_radius;
                tab_flags[index_a]  = body_flags;
            end
            else
                c = predict_contact(index_a, index_b);
            expected_contacts.insert(expected_contacts.size(), c);
        end
    end

    // Output side: compare each result transfer with the oldest prediction.
    initial fail_count = 0;
    always @(posedge clk)
    begin
        contact_t w;
        if (rst_n && pop && !empty)
        begin
            if (expected_contacts.size() == 0)
                report_mismatch("unexpected result", contact_found, 0);
            else
            begin
                w = expected_contacts.pop_front();
                if (contact_found !== w.found)
                    report_mismatch("contact_found", contact_found, w.found);
                if (normal_x !== w.nx) report_mismatch("normal_x", normal_x, w.nx);
                if (normal_y !== w.ny) report_mismatch("normal_y", normal_y, w.ny);
                if (normal_z !== w.nz) report_mismatch("normal_z", normal_z, w.nz);
                if (penetration !== w.pen)
                    report_mismatch("penetration", penetration, w.pen);
            end
        end
    end
endmodule

// ===== test/testbench.sv =====
// Top of the sphere pair contact testbench: clock, reset, stimulus and verdict.
// Depends on spc_pkg, sphere_pair_contact_top and spc_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               command = spc_pkg::CMD_WRITE;
    logic [5:0]         index_a = '0;
    logic [5:0]         index_b = '0;
    logic signed [31:0] sector_x = '0;
    logic signed [31:0] sector_y = '0;
    logic signed [31:0] sector_z = '0;
    logic signed [31:0] local_x = '0;
    logic signed [31:0] local_y = '0;
    logic signed [31:0] local_z = '0;
    logic signed [31:0] body_radius = '0;
    logic [2:0]         body_flags = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic               contact_found;
    logic signed [31:0] normal_x, normal_y, normal_z;
    logic [30:0]        penetration;
    int                 fail_count, pending_count;
    logic               hold_off = 1'b0;
    int                 idle_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sphere_pair_contact_top DUT (.*);

    spc_checker u_checker (.*);

    // Receiver: random stall pattern, with a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_off)
            pop <= 1'b0;
        else
            case ($urandom_range(0, 3))
                0: pop <= 1'b0;
                1: pop <= 1'($urandom_range(0, 1));
                default: pop <= 1'b1;
            endcase
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    logic [5:0] written_slots[$];

    // Offer one item and hold it until the transfer happens.
    task automatic send_item(logic cmd, logic [5:0] a, logic [5:0] b, logic [31:0] sx,
                             logic [31:0] sy, logic [31:0] sz, logic [31:0] lx,
                             logic [31:0] ly, logic [31:0] lz, logic [31:0] r,
                             logic [2:0] f);
        command <= cmd; index_a <= a; index_b <= b;
        sector_x <= sx; sector_y <= sy; sector_z <= sz;
        local_x <= lx; local_y <= ly; local_z <= lz;
        body_radius <= r; body_flags <= f;
        push <= 1'b1;
        do @(posedge clk); while (full);
    endtask

    task automatic write_body(logic [5:0] a, logic [31:0] sx, logic [31:0] sy,
                              logic [31:0] sz, logic [31:0] lx, logic [31:0] ly,
                              logic [31:0] lz, logic [31:0] r, logic [2:0] f);
        send_item(spc_pkg::CMD_WRITE, a, 6'($urandom), sx, sy, sz, lx, ly, lz, r, f);
    endtask

    // Queries pick only written slots so no undefined entry is ever read.
    task automatic query_pair();
        logic [5:0] a, b;
        a = written_slots[$urandom_range(0, written_slots.size() - 1)];
        b = written_slots[$urandom_range(0, written_slots.size() - 1)];
        send_item(spc_pkg::CMD_QUERY, a, b, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, 3'($urandom));
    endtask

    // Random body near the origin cluster so that many pairs touch.
    task automatic random_body();
        logic [5:0] a;
        logic [31:0] lx, ly, lz, r;
        int wide;
        a = 6'($urandom);
        wide = $urandom_range(0, 9);
        lx = wide == 0 ? $urandom : $urandom_range(0, 2000) - 1000;
        ly = wide == 1 ? $urandom : $urandom_range(0, 2000) - 1000;
        lz = $urandom_range(0, 2000) - 1000;
        r = wide == 2 ? $urandom : $urandom_range(1, 1500);
        write_body(a, $urandom_range(0, 2) - 1, $urandom_range(0, 1),
                   wide == 3 ? $urandom : 0, lx, ly, lz, r,
                   $urandom_range(0, 9) < 7 ? 3'b101 : 3'($urandom));
        written_slots.insert(written_slots.size(), a);
    endtask

    initial
    begin
        int sent;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, coincident centers, full components, huge offsets.
        write_body(0, 0, 0, 0, 0, 0, 0, 100, 3'b101);
        write_body(1, 0, 0, 0, 0, 0, 0, 50, 3'b101);
        write_body(2, 1, 0, 0, -1048500, 0, 0, 100, 3'b011);
        write_body(3, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff, 3'b101);
        write_body(4, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff, 3'b111);
        write_body(5, 2, 0, 0, 0, 0, 0, 100, 3'b101);
        write_body(6, 0, -1, 1, 30, 0, 0, 32'sh80000000, 3'b001);
        write_body(63, 32'sh80000000, 32'sh7fffffff, 0, 0, 40, 0, 100, 3'b110);
        write_body(62, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0, 100, 3'b101);
        written_slots = '{0, 1, 2, 3, 4, 5, 6, 62, 63};
        send_item(spc_pkg::CMD_QUERY, 0, 1, '1, '1, '1, '1, '1, '1, '1, '1);
        send_item(spc_pkg::CMD_QUERY, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(spc_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(spc_pkg::CMD_QUERY, 0, 2, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(spc_pkg::CMD_QUERY, 3, 4, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(spc_pkg::CMD_QUERY, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(spc_pkg::CMD_QUERY, 0, 6, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(spc_pkg::CMD_QUERY, 62, 63, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(spc_pkg::CMD_QUERY, 2, 63, 0, 0, 0, 0, 0, 0, 0, 0);
        push <= 1'b0;
        @(posedge clk);

        // Long receiver hold-off while items keep coming, so the input stalls.
        hold_off <= 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off <= 1'b0;
            end
            repeat (12) random_body();
        join
        push <= 1'b0;
        @(posedge clk);

        // Random part in bursts; mostly queries on written slots.
        sent = 0;
        while (sent < 900)
        begin
            repeat ($urandom_range(1, 12))
            begin
                if ($urandom_range(0, 9) < 4) random_body();
                else query_pair();
                sent++;
            end
            push <= 1'b0;
            if (sent % 300 < 12)
                wait (pending_count == 0);
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 30) : 1) @(posedge clk);
        end
        push <= 1'b0;

        wait (pending_count == 0);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
